@@ sv/name_directory_table_defines.svh @@
// ----------------------------------------------------------------------------
// Name directory table assertion macros
// Shared concurrent assertion forms for the directory checker.
// ----------------------------------------------------------------------------
`ifndef NAME_DIRECTORY_TABLE_DEFINES_SVH
`define NAME_DIRECTORY_TABLE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define NDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define NDT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/ndt_pkg.sv @@
// ----------------------------------------------------------------------------
// Name directory table package
// Request kinds, result status codes and name type.
// ----------------------------------------------------------------------------
package ndt_pkg;

  localparam int unsigned NAME_W = 152;

  typedef logic [NAME_W-1:0] name_t;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_LIST   = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_MISS  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

endpackage

@@ sv/name_directory_table.sv @@
// ----------------------------------------------------------------------------
// Name directory table
// Single-level directory of 19-byte names held in one synchronous memory.
// Create, delete and search scan the stored names through the single read
// port, one name per cycle; list reads and emits one entry at a time, each
// read waiting until the output register is free.
// One request is handled at a time; a finished word may wait in the output
// register while the next request is taken.
// Reset empties the table at once (count to zero); no clearing pass is run.
// ----------------------------------------------------------------------------
module name_directory_table #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] name_bytes_low_i,
  input  logic [63:0] name_bytes_mid_i,
  input  logic [23:0] name_bytes_top_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [5:0]  position_o,
  output logic [5:0]  entry_count_o,
  output logic [63:0] out_bytes_low_o,
  output logic [63:0] out_bytes_mid_o,
  output logic [23:0] out_bytes_top_o,
  output logic        last_o
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DEL   = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_LRD   = 3'd4;
  localparam logic [2:0] S_LWAIT = 3'd5;

  ndt_pkg::name_t mem [ENTRIES];
  ndt_pkg::name_t rd_data_q;

  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  issue_q, issue_d;
  logic           rd_vld_q, rd_vld_d;
  logic [IW-1:0]  rd_idx_q, rd_idx_d;
  logic [IW-1:0]  slot_q, slot_d;
  logic [1:0]     kind_q;
  ndt_pkg::name_t name_q;
  logic [2:0]     res_status_q, res_status_d;
  logic [5:0]     res_pos_q, res_pos_d;

  logic           re, we;
  logic [IW-1:0]  ra, wa;
  ndt_pkg::name_t wd;

  logic           out_vld_q;
  logic           out_free, out_load;
  logic [2:0]     out_status_d;
  logic [5:0]     out_pos_d;
  ndt_pkg::name_t out_name_d, out_name_q;
  logic           out_last_d;
  logic [2:0]     out_status_q;
  logic [5:0]     out_pos_q;
  logic [5:0]     out_count_q;
  logic           out_last_q;

  logic           in_acc;
  logic [CW-1:0]  cnt_m1;
  logic [CW-1:0]  issue_p1;
  logic [5:0]     hit_pos;
  logic           match;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign cnt_m1     = count_q - CW'(1);
  assign issue_p1   = issue_q + CW'(1);
  assign hit_pos    = 6'({1'b0, rd_idx_q} + (IW + 1)'(1));
  assign match      = (rd_data_q == name_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    re           = 1'b0;
    ra           = issue_q[IW-1:0];
    we           = 1'b0;
    wa           = count_q[IW-1:0];
    wd           = name_q;
    out_load     = 1'b0;
    out_status_d = ndt_pkg::ST_OK;
    out_pos_d    = 6'd0;
    out_name_d   = '0;
    out_last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        issue_d = '0;
        if (in_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (kind_q == ndt_pkg::KIND_LIST) begin
          issue_d = '0;
          if (count_q == '0) begin
            res_status_d = ndt_pkg::ST_EMPTY;
            res_pos_d    = 6'd0;
            state_d      = S_DONE;
          end else begin
            state_d = S_LRD;
          end
        end else if (rd_vld_q && match) begin
          res_pos_d = hit_pos;
          if (kind_q == ndt_pkg::KIND_CREATE) begin
            res_status_d = ndt_pkg::ST_DUP;
            state_d      = S_DONE;
          end else if (kind_q == ndt_pkg::KIND_DELETE) begin
            res_status_d = ndt_pkg::ST_OK;
            re           = 1'b1;
            ra           = cnt_m1[IW-1:0];
            slot_d       = rd_idx_q;
            state_d      = S_DEL;
          end else begin
            res_status_d = ndt_pkg::ST_OK;
            state_d      = S_DONE;
          end
        end else if (issue_q < count_q) begin
          re       = 1'b1;
          ra       = issue_q[IW-1:0];
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[IW-1:0];
          issue_d  = issue_p1;
        end else begin
          state_d   = S_DONE;
          res_pos_d = 6'd0;
          if (kind_q == ndt_pkg::KIND_CREATE) begin
            if (count_q >= CW'(ENTRIES)) begin
              res_status_d = ndt_pkg::ST_FULL;
            end else begin
              we           = 1'b1;
              count_d      = count_q + CW'(1);
              res_status_d = ndt_pkg::ST_OK;
              res_pos_d    = 6'(count_q + CW'(1));
            end
          end else begin
            res_status_d = ndt_pkg::ST_MISS;
          end
        end
      end
      S_DEL: begin
        we      = 1'b1;
        wa      = slot_q;
        wd      = rd_data_q;
        count_d = cnt_m1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = res_pos_q;
          state_d      = S_IDLE;
        end
      end
      S_LRD: begin
        if (out_free) begin
          re      = 1'b1;
          ra      = issue_q[IW-1:0];
          state_d = S_LWAIT;
        end
      end
      S_LWAIT: begin
        out_load     = 1'b1;
        out_status_d = ndt_pkg::ST_OK;
        out_pos_d    = 6'(issue_p1);
        out_name_d   = rd_data_q;
        out_last_d   = (issue_p1 == count_q);
        issue_d      = issue_p1;
        state_d      = (issue_p1 == count_q) ? S_IDLE : S_LRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    if (in_acc) begin
      kind_q <= kind_i;
      name_q <= {name_bytes_top_i, name_bytes_mid_i, name_bytes_low_i};
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
      out_count_q  <= 6'(count_q);
      out_name_q   <= out_name_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_status_q;
  assign position_o      = out_pos_q;
  assign entry_count_o   = out_count_q;
  assign out_bytes_low_o = out_name_q[63:0];
  assign out_bytes_mid_o = out_name_q[127:64];
  assign out_bytes_top_o = out_name_q[151:128];
  assign last_o          = out_last_q;

endmodule

@@ sv/ndt_checker.sv @@
// ----------------------------------------------------------------------------
// Name directory table checker
// Port-level properties of the directory, bound to the top level.
// ----------------------------------------------------------------------------
`include "name_directory_table_defines.svh"

module ndt_checker #(
  parameter int unsigned ENTRIES = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  kind_i,
  input logic [63:0] name_bytes_low_i,
  input logic [63:0] name_bytes_mid_i,
  input logic [23:0] name_bytes_top_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [5:0]  position_o,
  input logic [5:0]  entry_count_o,
  input logic [63:0] out_bytes_low_o,
  input logic [63:0] out_bytes_mid_o,
  input logic [23:0] out_bytes_top_o,
  input logic        last_o
);

  `NDT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(position_o) && $stable(out_bytes_low_o) && $stable(last_o), "Stalled result word changed.")
  `NDT_ASSERT(a_busy, in_valid_i && !in_stall_o |=> in_stall_o, "Request word taken while busy.")
  `NDT_ASSERT(a_count, out_valid_o |-> (ENTRIES > 63) || (entry_count_o <= 6'(ENTRIES)), "Entry count above table size.")
  `NDT_ASSERT(a_nonlast, out_valid_o && !last_o |-> status_o == ndt_pkg::ST_OK, "Listed word with bad status.")
  `NDT_ASSERT_RST(a_reset, !rst_ni |-> !out_valid_o && !in_stall_o, "Handshake active in reset.")

endmodule

bind name_directory_table ndt_checker #(.ENTRIES(ENTRIES)) u_ndt_checker (.*);
